// ===== hdl/bmas_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and microcode ROM for the buzzer melody and alarm sequencer.
package bmas_pkg;

  localparam int MAX_NOTES_DEF = 16;
  localparam int CHIRP_COUNT   = 10;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_APPEND = 2'd1,
    FN_COMMIT = 2'd2,
    FN_ALARM  = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] note_hz;
    logic [15:0] note_ms;
    logic        alarm_on;
  } in_t;

  typedef struct packed {
    logic [15:0] tone_hz;
    logic        melody_busy;
    logic        alarm_sounding;
    logic        note_dropped;
  } out_t;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  localparam cfg_idx_t REG_END_GAP_MS     = 3'd0;
  localparam cfg_idx_t REG_CHIRP_HZ       = 3'd1;
  localparam cfg_idx_t REG_CHIRP_ON_MS    = 3'd2;
  localparam cfg_idx_t REG_SWEEP_START_HZ = 3'd3;
  localparam cfg_idx_t REG_SWEEP_STEP_HZ  = 3'd4;
  localparam cfg_idx_t REG_SWEEP_STEPS    = 3'd5;
  localparam cfg_idx_t REG_SWEEP_STEP_MS  = 3'd6;

  localparam logic [7:0]  RST_END_GAP_MS     = 8'd5;
  localparam logic [15:0] RST_CHIRP_HZ       = 16'd2500;
  localparam logic [7:0]  RST_CHIRP_ON_MS    = 8'd30;
  localparam logic [15:0] RST_SWEEP_START_HZ = 16'd2500;
  localparam logic [11:0] RST_SWEEP_STEP_HZ  = 12'd100;
  localparam logic [5:0]  RST_SWEEP_STEPS    = 6'd15;
  localparam logic [7:0]  RST_SWEEP_STEP_MS  = 8'd50;

  typedef logic [1:0] bank_t;
  localparam bank_t BANK_0 = 2'd0;
  localparam bank_t BANK_1 = 2'd1;
  localparam bank_t BANK_2 = 2'd2;

  typedef struct packed {
    logic [15:0] tone;
    logic [15:0] len;
  } note_t;

  typedef enum logic [5:0] {
    M_IDLE      = 6'b000001,
    M_NOTE      = 6'b000010,
    M_GAP       = 6'b000100,
    M_CHIRP     = 6'b001000,
    M_CHIRP_GAP = 6'b010000,
    M_SWEEP     = 6'b100000
  } mode_t;

  // silent ms after chirp i: 150 / (i + 1)
  localparam logic [7:0] CHIRP_GAP_MS [16] = '{
    8'd150, 8'd75, 8'd50, 8'd37, 8'd30, 8'd25, 8'd21, 8'd18,
    8'd16,  8'd15, 8'd13, 8'd12, 8'd11, 8'd10, 8'd10, 8'd9
  };

  typedef logic [3:0] upc_t;
  localparam upc_t U_FETCH  = 4'd0;
  localparam upc_t U_DECODE = 4'd1;
  localparam upc_t U_CHECK  = 4'd2;
  localparam upc_t U_IDLE   = 4'd3;
  localparam upc_t U_NOTE   = 4'd4;
  localparam upc_t U_GAP    = 4'd5;
  localparam upc_t U_CHIRP  = 4'd6;
  localparam upc_t U_CGAP   = 4'd7;
  localparam upc_t U_SWEEP  = 4'd8;
  localparam upc_t U_RD     = 4'd9;
  localparam upc_t U_LOAD   = 4'd10;
  localparam upc_t U_MUL    = 4'd11;
  localparam upc_t U_SWL    = 4'd12;
  localparam upc_t U_EMIT   = 4'd13;

  typedef enum logic [3:0] {
    OP_NONE, OP_CMD, OP_IDLE, OP_NOTE, OP_GAP, OP_CHIRP, OP_CGAP,
    OP_SWEEP, OP_LOAD, OP_MUL, OP_SWL, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_ACCEPT, C_TICK, C_DISPATCH, C_PLAY, C_NOTE_MORE,
    C_TO_SWEEP, C_SWEEP_ON, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  nxt_t;
    upc_t  nxt_f;
  } uword_t;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    case (a)
      U_FETCH:  w = '{OP_NONE,  C_ACCEPT,    U_DECODE, U_FETCH};
      U_DECODE: w = '{OP_CMD,   C_TICK,      U_CHECK,  U_EMIT};
      U_CHECK:  w = '{OP_NONE,  C_DISPATCH,  U_EMIT,   U_EMIT};
      U_IDLE:   w = '{OP_IDLE,  C_PLAY,      U_RD,     U_EMIT};
      U_NOTE:   w = '{OP_NOTE,  C_NOTE_MORE, U_RD,     U_CHECK};
      U_GAP:    w = '{OP_GAP,   C_ALWAYS,    U_CHECK,  U_CHECK};
      U_CHIRP:  w = '{OP_CHIRP, C_ALWAYS,    U_CHECK,  U_CHECK};
      U_CGAP:   w = '{OP_CGAP,  C_TO_SWEEP,  U_MUL,    U_CHECK};
      U_SWEEP:  w = '{OP_SWEEP, C_SWEEP_ON,  U_MUL,    U_CHECK};
      U_RD:     w = '{OP_NONE,  C_ALWAYS,    U_LOAD,   U_LOAD};
      U_LOAD:   w = '{OP_LOAD,  C_ALWAYS,    U_CHECK,  U_CHECK};
      U_MUL:    w = '{OP_MUL,   C_ALWAYS,    U_SWL,    U_SWL};
      U_SWL:    w = '{OP_SWL,   C_ALWAYS,    U_CHECK,  U_CHECK};
      U_EMIT:   w = '{OP_EMIT,  C_OUT_FREE,  U_FETCH,  U_EMIT};
      default:  w = '{OP_NONE,  C_ALWAYS,    U_FETCH,  U_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/buzzer_melody_alarm_sequencer_top.sv =====
`timescale 1ns / 1ps
// Top level: microcoded buzzer melody and alarm sequencer with note bank memory.
// Flow: fetch, decode; append/commit/alarm go straight to emit, while a tick first
//   passes the segment check, and each segment change adds microcode steps.
// One request is in work at a time; the worst case is a tick that chains through
//   zero-length notes, with a note memory read each time round the loop.
// Reset: synchronous active low; clears control, bank counts and registers to defaults,
//   note memory contents are not cleared.
module buzzer_melody_alarm_sequencer_top #(
  parameter int MAX_NOTES = bmas_pkg::MAX_NOTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmas_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmas_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bmas_pkg::cfg_idx_t  cfg_index,
  input  bmas_pkg::cfg_data_t cfg_data
);
  import bmas_pkg::*;

  localparam int DEPTH = 3 * MAX_NOTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_NOTES + 1);
  localparam int PW    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

  function automatic logic [AW-1:0] bank_base(input bank_t b);
    case (b)
      BANK_1:  return AW'(MAX_NOTES);
      BANK_2:  return AW'(2 * MAX_NOTES);
      default: return '0;
    endcase
  endfunction

  upc_t        upc_r, upc_nxt;
  in_t         item_r, item_nxt;
  logic        dropped_r, dropped_nxt;
  out_t        out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  mode_t       mode_r, mode_nxt;
  logic [15:0] tone_r, tone_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [3:0]  chirp_n_r, chirp_n_nxt;
  logic [5:0]  sweep_pos_r, sweep_pos_nxt;
  logic        alarm_r, alarm_nxt;
  logic [17:0] prod_r, prod_nxt;
  bank_t       build_r, build_nxt, pend_r, pend_nxt, play_r, play_nxt;
  logic [CW-1:0] cnt_r [3];
  logic [CW-1:0] cnt_nxt [3];

  logic [7:0]  end_gap_ms_r, chirp_on_ms_r, sweep_step_ms_r;
  logic [15:0] chirp_hz_r, sweep_start_hz_r;
  logic [11:0] sweep_step_hz_r;
  logic [5:0]  sweep_steps_r;

  note_t         mem [DEPTH];
  note_t         rd_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  uword_t      uw;
  logic        take, out_free, note_end, chirp_more, sweep_more, pend_full, build_full;
  logic [CW:0] pos_inc;
  logic [5:0]  steps_eff;
  logic [7:0]  chirp_on_eff, step_ms_eff;

  assign in_ready  = (upc_r == U_FETCH);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign wr_addr = bank_base(build_r) + AW'(cnt_r[build_r]);
  assign rd_addr = bank_base(play_r) + AW'(pos_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{tone: item_r.note_hz, len: item_r.note_ms};
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    uw           = ucode(upc_r);
    out_free     = !out_valid_r || out_ready;
    pos_inc      = (CW+1)'(pos_r) + (CW+1)'(1);
    note_end     = alarm_r || (pos_inc >= (CW+1)'(cnt_r[play_r])) || (cnt_r[pend_r] != '0);
    pend_full    = (cnt_r[pend_r] != '0);
    build_full   = (cnt_r[build_r] >= CW'(MAX_NOTES));
    chirp_more   = ((5'(chirp_n_r) + 5'd1) < 5'(CHIRP_COUNT));
    steps_eff    = (sweep_steps_r == '0) ? 6'd1 : sweep_steps_r;
    sweep_more   = ((7'(sweep_pos_r) + 7'd1) < 7'(steps_eff));
    chirp_on_eff = (chirp_on_ms_r == '0) ? 8'd1 : chirp_on_ms_r;
    step_ms_eff  = (sweep_step_ms_r == '0) ? 8'd1 : sweep_step_ms_r;

    item_nxt      = item_r;
    dropped_nxt   = dropped_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mode_nxt      = mode_r;
    tone_nxt      = tone_r;
    ms_nxt        = ms_r;
    pos_nxt       = pos_r;
    chirp_n_nxt   = chirp_n_r;
    sweep_pos_nxt = sweep_pos_r;
    alarm_nxt     = alarm_r;
    prod_nxt      = prod_r;
    build_nxt     = build_r;
    pend_nxt      = pend_r;
    play_nxt      = play_r;
    cnt_nxt       = cnt_r;
    wr_en         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      item_nxt = in_data;
    end

    case (uw.op)
      OP_CMD: begin
        dropped_nxt = 1'b0;
        case (item_r.func)
          FN_APPEND: begin
            if (build_full) begin
              dropped_nxt = 1'b1;
            end else begin
              wr_en = 1'b1;
              cnt_nxt[build_r] = cnt_r[build_r] + CW'(1);
            end
          end
          FN_COMMIT: begin
            build_nxt = pend_r;
            pend_nxt  = build_r;
            cnt_nxt[pend_r] = '0;
          end
          FN_ALARM: alarm_nxt = item_r.alarm_on;
          default: ;
        endcase
      end
      OP_IDLE: begin
        if (alarm_r) begin
          chirp_n_nxt = '0;
          mode_nxt    = M_CHIRP;
          tone_nxt    = chirp_hz_r;
          ms_nxt      = 16'(chirp_on_eff);
        end else if (pend_full) begin
          pend_nxt = play_r;
          play_nxt = pend_r;
          cnt_nxt[play_r] = '0;
          pos_nxt  = '0;
          mode_nxt = M_NOTE;
        end else begin
          tone_nxt = '0;
          ms_nxt   = 16'(end_gap_ms_r);
        end
      end
      OP_NOTE: begin
        if (note_end) begin
          mode_nxt = M_GAP;
          tone_nxt = '0;
          ms_nxt   = 16'(end_gap_ms_r);
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end
      OP_GAP: mode_nxt = M_IDLE;
      OP_CHIRP: begin
        mode_nxt = M_CHIRP_GAP;
        tone_nxt = '0;
        ms_nxt   = 16'(CHIRP_GAP_MS[chirp_n_r]);
      end
      OP_CGAP: begin
        if (!alarm_r) begin
          mode_nxt = M_IDLE;
        end else if (chirp_more) begin
          chirp_n_nxt = chirp_n_r + 4'd1;
          mode_nxt    = M_CHIRP;
          tone_nxt    = chirp_hz_r;
          ms_nxt      = 16'(chirp_on_eff);
        end else begin
          sweep_pos_nxt = '0;
          mode_nxt      = M_SWEEP;
        end
      end
      OP_SWEEP: begin
        if (sweep_more) begin
          sweep_pos_nxt = sweep_pos_r + 6'd1;
        end else if (alarm_r) begin
          sweep_pos_nxt = '0;
        end else begin
          mode_nxt = M_IDLE;
        end
      end
      OP_LOAD: begin
        tone_nxt = rd_q.tone;
        ms_nxt   = rd_q.len;
      end
      OP_MUL: prod_nxt = 18'(sweep_pos_r) * 18'(sweep_step_hz_r);
      OP_SWL: begin
        tone_nxt = sweep_start_hz_r + prod_r[15:0];
        ms_nxt   = 16'(step_ms_eff);
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_nxt.tone_hz            = tone_r;
          out_nxt.melody_busy        = (mode_r == M_NOTE) || (mode_r == M_GAP);
          out_nxt.alarm_sounding     = (mode_r == M_CHIRP) || (mode_r == M_CHIRP_GAP) ||
                                       (mode_r == M_SWEEP);
          out_nxt.note_dropped       = dropped_r;
          if ((item_r.func == FN_TICK) && (ms_r != '0)) begin
            ms_nxt = ms_r - 16'd1;
          end
        end
      end
      default: ;
    endcase

    case (uw.cond)
      C_ALWAYS:    take = 1'b1;
      C_ACCEPT:    take = in_valid;
      C_TICK:      take = (item_r.func == FN_TICK);
      C_PLAY:      take = !alarm_r && pend_full;
      C_NOTE_MORE: take = !note_end;
      C_TO_SWEEP:  take = alarm_r && !chirp_more;
      C_SWEEP_ON:  take = sweep_more || alarm_r;
      C_OUT_FREE:  take = out_free;
      default:     take = 1'b0;
    endcase
    upc_nxt = take ? uw.nxt_t : uw.nxt_f;

    if ((uw.cond == C_DISPATCH) && (ms_r == '0)) begin
      case (mode_r)
        M_NOTE:      upc_nxt = U_NOTE;
        M_GAP:       upc_nxt = U_GAP;
        M_CHIRP:     upc_nxt = U_CHIRP;
        M_CHIRP_GAP: upc_nxt = U_CGAP;
        M_SWEEP:     upc_nxt = U_SWEEP;
        default:     upc_nxt = U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    dropped_r <= dropped_nxt;
    out_r     <= out_nxt;
    prod_r    <= prod_nxt;
    if (!rst_n) begin
      upc_r            <= U_FETCH;
      out_valid_r      <= 1'b0;
      mode_r           <= M_IDLE;
      tone_r           <= '0;
      ms_r             <= '0;
      pos_r            <= '0;
      chirp_n_r        <= '0;
      sweep_pos_r      <= '0;
      alarm_r          <= 1'b0;
      build_r          <= BANK_0;
      pend_r           <= BANK_1;
      play_r           <= BANK_2;
      cnt_r            <= '{default: '0};
      end_gap_ms_r     <= RST_END_GAP_MS;
      chirp_hz_r       <= RST_CHIRP_HZ;
      chirp_on_ms_r    <= RST_CHIRP_ON_MS;
      sweep_start_hz_r <= RST_SWEEP_START_HZ;
      sweep_step_hz_r  <= RST_SWEEP_STEP_HZ;
      sweep_steps_r    <= RST_SWEEP_STEPS;
      sweep_step_ms_r  <= RST_SWEEP_STEP_MS;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      tone_r      <= tone_nxt;
      ms_r        <= ms_nxt;
      pos_r       <= pos_nxt;
      chirp_n_r   <= chirp_n_nxt;
      sweep_pos_r <= sweep_pos_nxt;
      alarm_r     <= alarm_nxt;
      build_r     <= build_nxt;
      pend_r      <= pend_nxt;
      play_r      <= play_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_END_GAP_MS:     end_gap_ms_r     <= cfg_data[7:0];
          REG_CHIRP_HZ:       chirp_hz_r       <= cfg_data;
          REG_CHIRP_ON_MS:    chirp_on_ms_r    <= cfg_data[7:0];
          REG_SWEEP_START_HZ: sweep_start_hz_r <= cfg_data;
          REG_SWEEP_STEP_HZ:  sweep_step_hz_r  <= cfg_data[11:0];
          REG_SWEEP_STEPS:    sweep_steps_r    <= cfg_data[5:0];
          REG_SWEEP_STEP_MS:  sweep_step_ms_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/bmas_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertion checker for the sequencer, bound to the top level.
module bmas_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input bmas_pkg::in_t       in_data,
  input logic                out_valid,
  input logic                out_ready,
  input bmas_pkg::out_t      out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input bmas_pkg::cfg_idx_t  cfg_index,
  input bmas_pkg::cfg_data_t cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in work");

  // melody and alarm never report together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.melody_busy && out_data.alarm_sounding))
    else $error("melody and alarm both active");

endmodule

bind buzzer_melody_alarm_sequencer_top bmas_checker u_bmas_checker (.*);

// ===== tb/buzzer_tone_checker.sv =====
`timescale 1ns / 1ps
// Checker for the buzzer sequencer: predicts every result from accepted requests and compares.
module buzzer_tone_checker
  import bmas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_t       in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_t      out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data,
  output int        outstanding,
  output int        mismatches
);

  localparam int NOTES          = MAX_NOTES_DEF;
  localparam int BANKS          = 3;
  localparam int CHIRP_GAP_BASE = 150;
  localparam int REPORT_MAX     = 100;

  logic [15:0] tone_mem [BANKS * NOTES];
  logic [15:0] len_mem  [BANKS * NOTES];
  logic [4:0]  bank_count [BANKS];
  bank_t       build_bank, pend_bank, play_bank;
  mode_t       mode;
  logic [3:0]  note_idx;
  logic [15:0] ms_left;
  logic [3:0]  chirp_idx;
  logic        gap_phase;
  logic [5:0]  sweep_idx;
  logic        alarm_req;
  logic [15:0] tone_now;

  logic [7:0]  gap_cfg;
  logic [15:0] chirp_tone_cfg;
  logic [7:0]  chirp_len_cfg;
  logic [15:0] sweep_base_cfg;
  logic [11:0] sweep_inc_cfg;
  logic [5:0]  sweep_count_cfg;
  logic [7:0]  sweep_len_cfg;

  out_t tone_due [$];
  int   errs = 0;

  function automatic void reset_model();
    for (int b = 0; b < BANKS; b++) bank_count[b] = '0;
    build_bank      = BANK_0;
    pend_bank       = BANK_1;
    play_bank       = BANK_2;
    mode            = M_IDLE;
    note_idx        = '0;
    ms_left         = '0;
    chirp_idx       = '0;
    gap_phase       = 1'b0;
    sweep_idx       = '0;
    alarm_req       = 1'b0;
    tone_now        = '0;
    gap_cfg         = RST_END_GAP_MS;
    chirp_tone_cfg  = RST_CHIRP_HZ;
    chirp_len_cfg   = RST_CHIRP_ON_MS;
    sweep_base_cfg  = RST_SWEEP_START_HZ;
    sweep_inc_cfg   = RST_SWEEP_STEP_HZ;
    sweep_count_cfg = RST_SWEEP_STEPS;
    sweep_len_cfg   = RST_SWEEP_STEP_MS;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, cfg_data_t val);
    case (idx)
      REG_END_GAP_MS:     gap_cfg         = val[7:0];
      REG_CHIRP_HZ:       chirp_tone_cfg  = val;
      REG_CHIRP_ON_MS:    chirp_len_cfg   = val[7:0];
      REG_SWEEP_START_HZ: sweep_base_cfg  = val;
      REG_SWEEP_STEP_HZ:  sweep_inc_cfg   = val[11:0];
      REG_SWEEP_STEPS:    sweep_count_cfg = val[5:0];
      REG_SWEEP_STEP_MS:  sweep_len_cfg   = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic void fetch_note();
    int slot;
    slot     = int'(play_bank) * NOTES + int'(note_idx);
    tone_now = tone_mem[slot];
    ms_left  = len_mem[slot];
  endfunction

  function automatic void begin_chirp();
    mode      = M_CHIRP;
    gap_phase = 1'b0;
    tone_now  = chirp_tone_cfg;
    ms_left   = (chirp_len_cfg == 0) ? 16'd1 : 16'(chirp_len_cfg);
  endfunction

  function automatic void begin_sweep_step();
    logic [31:0] f;
    f        = 32'(sweep_base_cfg) + 32'(sweep_idx) * 32'(sweep_inc_cfg);
    mode     = M_SWEEP;
    tone_now = f[15:0];
    ms_left  = (sweep_len_cfg == 0) ? 16'd1 : 16'(sweep_len_cfg);
  endfunction

  // Replace expired segments until one with time left is in force, or idle with a zero gap.
  function automatic void run_segments();
    bank_t t;
    int    steps;
    steps = (sweep_count_cfg == 0) ? 1 : int'(sweep_count_cfg);
    for (int guard = 0; guard < 4 * NOTES + 64; guard++) begin
      if (ms_left != 0) return;
      case (mode)
        M_NOTE: begin
          if (alarm_req || int'(note_idx) + 1 >= int'(bank_count[play_bank]) ||
              bank_count[pend_bank] != 0) begin
            mode     = M_GAP;
            tone_now = '0;
            ms_left  = 16'(gap_cfg);
          end else begin
            note_idx++;
            fetch_note();
          end
        end
        M_GAP: mode = M_IDLE;
        M_CHIRP: begin
          mode      = M_CHIRP_GAP;
          gap_phase = 1'b1;
          tone_now  = '0;
          ms_left   = 16'(CHIRP_GAP_BASE / (int'(chirp_idx) + 1));
        end
        M_CHIRP_GAP: begin
          gap_phase = 1'b0;
          if (!alarm_req) begin
            mode = M_IDLE;
          end else if (int'(chirp_idx) + 1 < CHIRP_COUNT) begin
            chirp_idx++;
            begin_chirp();
          end else begin
            sweep_idx = '0;
            begin_sweep_step();
          end
        end
        M_SWEEP: begin
          if (int'(sweep_idx) + 1 < steps) begin
            sweep_idx++;
            begin_sweep_step();
          end else if (alarm_req) begin
            sweep_idx = '0;
            begin_sweep_step();
          end else begin
            mode = M_IDLE;
          end
        end
        default: begin
          mode = M_IDLE;
          if (alarm_req) begin
            chirp_idx = '0;
            begin_chirp();
          end else if (bank_count[pend_bank] != 0) begin
            t                     = pend_bank;
            pend_bank             = play_bank;
            play_bank             = t;
            bank_count[pend_bank] = '0;
            note_idx              = '0;
            mode                  = M_NOTE;
            fetch_note();
          end else begin
            tone_now = '0;
            ms_left  = 16'(gap_cfg);
            if (ms_left == 0) return;
          end
        end
      endcase
    end
  endfunction

  function automatic out_t predict_tone(in_t rq);
    out_t  r;
    bank_t t;
    int    slot;
    r = '0;
    case (rq.func)
      FN_TICK: run_segments();
      FN_APPEND: begin
        if (bank_count[build_bank] >= NOTES) begin
          r.note_dropped = 1'b1;
        end else begin
          slot           = int'(build_bank) * NOTES + int'(bank_count[build_bank]);
          tone_mem[slot] = rq.note_hz;
          len_mem[slot]  = rq.note_ms;
          bank_count[build_bank]++;
        end
      end
      FN_COMMIT: begin
        t                      = build_bank;
        build_bank             = pend_bank;
        pend_bank              = t;
        bank_count[build_bank] = '0;
      end
      default: alarm_req = rq.alarm_on;
    endcase
    r.tone_hz        = tone_now;
    r.melody_busy    = (mode == M_NOTE || mode == M_GAP);
    r.alarm_sounding = (mode == M_CHIRP || mode == M_CHIRP_GAP || mode == M_SWEEP);
    if (rq.func == FN_TICK && ms_left != 0) ms_left--;
    return r;
  endfunction

  function automatic int field_diff(string name, int want, int got);
    if (want == got) return 0;
    if (errs < REPORT_MAX) $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      reset_model();
      tone_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (tone_due.size() == 0) begin
          if (errs < REPORT_MAX) $error("result with no request waiting: tone_hz %0d",
                                        out_data.tone_hz);
          errs++;
        end else begin
          want = tone_due.pop_front();
          errs += field_diff("tone_hz", want.tone_hz, out_data.tone_hz);
          errs += field_diff("melody_busy", want.melody_busy, out_data.melody_busy);
          errs += field_diff("alarm_sounding", want.alarm_sounding, out_data.alarm_sounding);
          errs += field_diff("note_dropped", want.note_dropped, out_data.note_dropped);
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) tone_due.push_back(predict_tone(in_data));
    end
    outstanding <= tone_due.size();
    mismatches  <= errs;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: request stimulus, result stalls, register phases, watchdog and verdict.
module tb;
  import bmas_pkg::*;

  localparam int SETTLE         = 4 * MAX_NOTES_DEF + 36;
  localparam int LONG_HOLD      = 300;
  localparam int STALL_LIMIT    = 20000;
  localparam int CHIRP_GAP_BASE = 150;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_t       in_data   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data  = '0;
  logic      in_ready, out_valid, cfg_ready;
  out_t      out_data;
  int        outstanding, mismatches;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_toggle  = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;
  int   idle_cycles  = 0;
  int   sent         = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  buzzer_melody_alarm_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  buzzer_tone_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // result side: random stalls, plus a long hold each time hold_toggle flips
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  function automatic in_t req(func_t f, logic [15:0] hz, logic [15:0] ms, logic on);
    in_t r;
    r.func     = f;
    r.note_hz  = hz;
    r.note_ms  = ms;
    r.alarm_on = on;
    return r;
  endfunction

  function automatic logic [15:0] rand_tone();
    return ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_len();
    int p;
    p = $urandom_range(99);
    if (p < 25) return 16'd0;
    if (p < 90) return 16'($urandom_range(5, 1));
    return 16'($urandom_range(20, 6));
  endfunction

  task automatic send_item(in_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(req(FN_TICK, 16'($urandom), 16'($urandom), 1'($urandom)));
  endtask

  task automatic set_alarm(logic on);
    send_item(req(FN_ALARM, 16'($urandom), 16'($urandom), on));
  endtask

  task automatic commit_melody();
    send_item(req(FN_COMMIT, 16'($urandom), 16'($urandom), 1'($urandom)));
  endtask

  task automatic append_notes(int n);
    repeat (n) send_item(req(FN_APPEND, rand_tone(), rand_len(), 1'($urandom)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(logic [7:0] gap, logic [15:0] chirp, logic [7:0] chirp_len,
                          logic [15:0] base, logic [11:0] inc, logic [5:0] steps,
                          logic [7:0] step_len);
    write_reg(REG_END_GAP_MS, 16'(gap));
    write_reg(REG_CHIRP_HZ, chirp);
    write_reg(REG_CHIRP_ON_MS, 16'(chirp_len));
    write_reg(REG_SWEEP_START_HZ, base);
    write_reg(REG_SWEEP_STEP_HZ, 16'(inc));
    write_reg(REG_SWEEP_STEPS, 16'(steps));
    write_reg(REG_SWEEP_STEP_MS, 16'(step_len));
    cfg_valid <= 1'b0;
  endtask

  task automatic set_random_regs(int gap_max);
    set_regs(8'($urandom_range(gap_max)), 16'($urandom), 8'($urandom_range(40, 1)),
             16'($urandom), 12'($urandom), 6'($urandom_range(63, 1)),
             8'($urandom_range(10, 1)));
  endtask

  task automatic random_mix(int n);
    int    stop;
    int    pick;
    func_t f;
    stop = sent + n;
    while (sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        append_notes(($urandom_range(3) == 0) ? $urandom_range(18, 12) : $urandom_range(5, 1));
        if ($urandom_range(9) != 0) commit_melody();
        ticks($urandom_range(30, 5));
      end else if (pick < 72) begin
        ticks($urandom_range(25, 1));
      end else if (pick < 77) begin
        set_alarm(1'b1);
        if ($urandom_range(2) == 0) ticks($urandom_range(3, 1));
        set_alarm(1'b0);
      end else if (pick < 88) begin
        commit_melody();
      end else begin
        f = func_t'($urandom_range(3));
        send_item(req(f, 16'($urandom), (f == FN_APPEND) ? rand_len() : 16'($urandom),
                      (f == FN_ALARM) ? 1'b0 : 1'($urandom)));
      end
    end
  endtask

  // alarm held through all chirps into repeating sweeps, a melody waiting behind it
  task automatic sweep_walk();
    int chirp_ticks;
    int i;
    chirp_ticks = 0;
    for (i = 0; i < CHIRP_COUNT; i++) chirp_ticks += 1 + CHIRP_GAP_BASE / (i + 1);
    set_alarm(1'b1);
    append_notes(3);
    commit_melody();
    ticks(chirp_ticks + 30);
    drain();
    set_regs(8'd2, 16'($urandom), 8'd0, 16'($urandom), 12'($urandom), 6'd0, 8'd0);
    ticks(8);
    set_alarm(1'b0);
    ticks(15);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full bank with all-ones notes, drop, lost pending melody, alarm toggle
    ticks(1);
    repeat (16) send_item(req(FN_APPEND, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(req(FN_APPEND, 16'h0000, 16'h0000, 1'b0));
    commit_melody();
    commit_melody();
    set_alarm(1'b1);
    set_alarm(1'b0);
    ticks(1);
    drain();

    // minimum settings (chirp tone at maximum), no idling, one long result hold
    set_regs(8'd0, 16'hFFFF, 8'd0, 16'd0, 12'd0, 6'd0, 8'd0);
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    hold_toggle <= ~hold_toggle;
    random_mix(20);
    drain();

    tx_idle_pct = 32;
    rx_stall_pct <= 32;
    set_regs(8'd2, 16'($urandom), 8'd1, 16'hFFFF, 12'hFFF, 6'd63, 8'd1);
    sweep_walk();
    drain();

    // maximum lengths
    tx_idle_pct = 73;
    rx_stall_pct <= 0;
    set_regs(8'd255, 16'($urandom), 8'd255, 16'($urandom), 12'($urandom),
             6'($urandom_range(63, 1)), 8'd255);
    random_mix(20);
    drain();

    tx_idle_pct = 0;
    rx_stall_pct <= 73;
    set_random_regs(8);
    random_mix(10);
    drain();
    random_mix(10);
    drain();

    tx_idle_pct = 32;
    rx_stall_pct <= 32;
    set_random_regs(5);
    random_mix(20);
    drain();

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
